>>> rtl/iis_pkg.sv
// Shared types, sizes, status codes and ring-index helper for the IMU interval segmenter.
// Depends on nothing; iis_interp and the core import it.
`timescale 1ns / 1ps

package iis_pkg;

	// Ring and count sizes.
	localparam int BUFFER_DEPTH = 32;
	localparam int PTR_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
	localparam int SEG_DEPTH    = BUFFER_DEPTH - 1;
	localparam int SEG_AW       = $clog2(SEG_DEPTH);

	// Datapath widths.
	localparam int STAMP_W   = 48;
	localparam int VAL_W     = 32;
	localparam int NCOMP     = 6;
	localparam int DIV_STEPS = 2 * VAL_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);
	localparam int SUMSQ_W   = 63;

	localparam logic [VAL_W-1:0] GAP_RESET = 32'd20000;

	// Result status codes.
	localparam logic [3:0] ST_ACCEPTED     = 4'd0;
	localparam logic [3:0] ST_INVALID      = 4'd1;
	localparam logic [3:0] ST_DUPLICATE    = 4'd2;
	localparam logic [3:0] ST_NONMONOTONIC = 4'd3;
	localparam logic [3:0] ST_FULL         = 4'd4;
	localparam logic [3:0] ST_SEGMENT      = 4'd5;
	localparam logic [3:0] ST_OK           = 4'd6;
	localparam logic [3:0] ST_BAD_INTERVAL = 4'd7;
	localparam logic [3:0] ST_INSUFFICIENT = 4'd8;
	localparam logic [3:0] ST_UNBRACKETED  = 4'd9;
	localparam logic [3:0] ST_GAP          = 4'd10;

	localparam logic KIND_ADD = 1'b0;

	typedef struct packed {
		logic                      kind;
		logic [STAMP_W-1:0]        sample_time;
		logic [STAMP_W-1:0]        interval_start;
		logic [STAMP_W-1:0]        interval_end;
		logic signed [VAL_W-1:0]   accel_x;
		logic signed [VAL_W-1:0]   accel_y;
		logic signed [VAL_W-1:0]   accel_z;
		logic signed [VAL_W-1:0]   rate_x;
		logic signed [VAL_W-1:0]   rate_y;
		logic signed [VAL_W-1:0]   rate_z;
	} item_t;

	typedef struct packed {
		logic [3:0]                status;
		logic signed [VAL_W-1:0]   mean_accel_x;
		logic signed [VAL_W-1:0]   mean_accel_y;
		logic signed [VAL_W-1:0]   mean_accel_z;
		logic signed [VAL_W-1:0]   mean_rate_x;
		logic signed [VAL_W-1:0]   mean_rate_y;
		logic signed [VAL_W-1:0]   mean_rate_z;
		logic [VAL_W-1:0]          segment_dt;
		logic [VAL_W-1:0]          median_dt;
		logic [SUMSQ_W-1:0]        sum_dt_squared;
		logic [5:0]                owned_count;
		logic                      last;
	} result_t;

	// One ring entry: stamp plus accel x/y/z (0..2) and rate x/y/z (3..5).
	typedef struct packed {
		logic [STAMP_W-1:0]          stamp;
		logic [NCOMP-1:0][VAL_W-1:0] comp;
	} sample_t;

	// Ring slot of logical index idx, counted from the head.
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
			input logic [CNT_W-1:0] idx);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
		if (sum >= (CNT_W + 1)'(BUFFER_DEPTH)) begin
			sum = sum - (CNT_W + 1)'(BUFFER_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

>>> rtl/iis_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module iis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/iis_interp.sv
// Interpolation unit: l + floor((r - l) * num / den) with a bit-serial divider.
// Depends on iis_pkg.
`timescale 1ns / 1ps

module iis_interp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [iis_pkg::VAL_W-1:0] lval,
	input  logic signed [iis_pkg::VAL_W-1:0] rval,
	input  logic [iis_pkg::VAL_W-1:0]      num,
	input  logic [iis_pkg::VAL_W-1:0]      den,
	output logic                           done,
	output logic signed [iis_pkg::VAL_W-1:0] result
);
	import iis_pkg::*;

	localparam int PW = 2 * VAL_W;

	logic signed [VAL_W:0]   diff;
	logic [VAL_W:0]          mag;
	logic [PW-1:0]           prod;
	logic [VAL_W:0]          rem_sh;
	logic                    fits;
	logic [VAL_W+2:0]        l_ext;
	logic [VAL_W+2:0]        quo_ext;
	logic [VAL_W+2:0]        res_w;

	logic [PW-1:0]           dvd_q;
	logic [VAL_W-1:0]        rem_q;
	logic [VAL_W-1:0]        den_q;
	logic signed [VAL_W-1:0] l_q;
	logic                    neg_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CW-1:0]       cnt_q;

	// Magnitude of the span and its product with the offset.
	assign diff = $signed({rval[VAL_W-1], rval}) - $signed({lval[VAL_W-1], lval});
	assign mag  = diff[VAL_W] ? (~diff + 1'b1) : diff;
	assign prod = PW'(mag) * PW'(num);

	// One restoring division step.
	assign rem_sh = {rem_q, dvd_q[PW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// Floor result: a negative span rounds its magnitude up.
	assign l_ext   = {{3{l_q[VAL_W-1]}}, l_q};
	assign quo_ext = (VAL_W + 3)'(dvd_q[VAL_W:0]);
	assign res_w   = neg_q ? (l_ext - quo_ext - (VAL_W + 3)'(rem_q != '0))
	                       : (l_ext + quo_ext);
	assign result  = res_w[VAL_W-1:0];
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			l_q    <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= prod;
				rem_q  <= '0;
				den_q  <= den;
				l_q    <= lval;
				neg_q  <= diff[VAL_W];
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[PW-2:0], fits};
				rem_q <= fits ? VAL_W'(rem_sh - {1'b0, den_q}) : rem_sh[VAL_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A finished result never appears while a division is still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("interpolation done while busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("interpolation restarted while busy");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> cnt_q == '0)
		else $error("division step count not cleared");

endmodule

>>> rtl/imu_interval_segmenter_core.sv
// Top level of the IMU interval segmenter: sample ring, duration memory, sequencer.
// Depends on iis_pkg, iis_ram and iis_interp.
//
//   channel  | direction | handshake           | payload
//   item     | in        | item_valid/stall    | iis_pkg::item_t
//   result   | out       | result_valid/stall  | iis_pkg::result_t
//   cfg      | in        | cfg_valid/ready     | max_gap_us, 32 bits
//
// An extract runs the 64-step serial divider of the interpolation once for each
// component of both knots, and the median scan over the duration memory. The
// next item is taken once the previous one is finished. Reset empties the ring
// at once; no memory is cleared. A stalled result holds the sequencer before
// its next transfer.
`timescale 1ns / 1ps

module imu_interval_segmenter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  iis_pkg::item_t     item,
	output logic               result_valid,
	input  logic               result_stall,
	output iis_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import iis_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE    = 17'b00000000000000001,
		S_SCAN    = 17'b00000000000000010,
		S_CHECK   = 17'b00000000000000100,
		S_ERR     = 17'b00000000000001000,
		S_RDA     = 17'b00000000000010000,
		S_RDB     = 17'b00000000000100000,
		S_LATB    = 17'b00000000001000000,
		S_IGO     = 17'b00000000010000000,
		S_IWAIT   = 17'b00000000100000000,
		S_INNER   = 17'b00000001000000000,
		S_INNER_W = 17'b00000010000000000,
		S_SEG     = 17'b00000100000000000,
		S_MLOAD   = 17'b00001000000000000,
		S_MLOADW  = 17'b00010000000000000,
		S_MSCAN   = 17'b00100000000000000,
		S_MEVAL   = 17'b01000000000000000,
		S_FINAL   = 17'b10000000000000000
	} state_t;

	localparam logic [SUMSQ_W-1:0] SAT63 = {SUMSQ_W{1'b1}};

	state_t state_q;

	// Ring bookkeeping and configuration.
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   fill_q;
	logic [STAMP_W-1:0] last_q;
	logic [VAL_W-1:0]   gap_q;

	// Extract context.
	logic [STAMP_W-1:0] start_q, end_q, prev_t_q;
	logic [CNT_W-1:0]   iss_q, pidx_q;
	logic               pend_q;
	logic [PTR_W-1:0]   left_q, right_q, inner_q;
	logic               have_left_q, gapbad_q, eq_q, knot_end_q;
	logic [3:0]         err_q;
	sample_t            a_q, b_q;
	logic [2:0]         comp_q;
	logic [NCOMP-1:0][VAL_W-1:0] kprev_q, kcur_q;
	logic [STAMP_W-1:0] kprev_t_q, kcur_t_q;
	logic [CNT_W-1:0]   seg_q;
	logic [SUMSQ_W-1:0] sum_q;
	logic               sq_vld_s1;
	logic [2*VAL_W-1:0] sq_s1;

	// Median selection.
	logic [CNT_W-1:0]   j_q, i_q, lt_q, le_q;
	logic [VAL_W-1:0]   cand_q, sel1_q, sel2_q;

	// Result register.
	result_t            res_q;
	logic               res_vld_q;

	// Combinational signals.
	logic               out_free, item_accept, res_load;
	result_t            res_n;
	logic [3:0]         add_code;
	logic               ext_early_err;
	logic [3:0]         ext_code;
	logic [PTR_W-1:0]   ia;
	logic [STAMP_W-1:0] knot_t;
	logic [STAMP_W-1:0] scan_t;
	logic               scan_le_start, scan_ge_end, scan_found, gap_hit, scan_issue;
	logic               mscan_issue;
	logic [VAL_W-1:0]   dt;
	logic [VAL_W:0]     med_sum;
	logic [CNT_W-1:0]   k1, k2, drop, owned;
	logic [SUMSQ_W+1:0] sum_tot;
	logic [NCOMP-1:0][VAL_W-1:0] mean;
	logic [VAL_W:0]     msum [NCOMP];

	logic               s_we;
	logic [PTR_W-1:0]   s_waddr, s_raddr;
	sample_t            s_wdata, s_rdata;
	logic               d_we;
	logic [SEG_AW-1:0]  d_waddr, d_raddr;
	logic [VAL_W-1:0]   d_rdata;

	logic               ip_start, ip_done;
	logic signed [VAL_W-1:0] ip_res;

	// Memories: sample ring and segment durations.
	iis_ram #(.WIDTH($bits(sample_t)), .DEPTH(BUFFER_DEPTH)) u_sample_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	iis_ram #(.WIDTH(VAL_W), .DEPTH(SEG_DEPTH)) u_dur_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (dt),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// Shared interpolation unit.
	assign ip_start = (state_q == S_IGO);

	iis_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ip_start),
		.lval   (a_q.comp[comp_q]),
		.rval   (b_q.comp[comp_q]),
		.num    (VAL_W'(knot_t - a_q.stamp)),
		.den    (VAL_W'(b_q.stamp - a_q.stamp)),
		.done   (ip_done),
		.result (ip_res)
	);

	// Handshakes.
	assign out_free     = !res_vld_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE) || !out_free;
	assign item_accept  = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_vld_q;
	assign result       = res_q;

	// Add checks.
	always_comb begin
		if (item.sample_time == '0) begin
			add_code = ST_INVALID;
		end else if (fill_q != '0 && item.sample_time == last_q) begin
			add_code = ST_DUPLICATE;
		end else if (fill_q != '0 && item.sample_time < last_q) begin
			add_code = ST_NONMONOTONIC;
		end else if (fill_q == CNT_W'(BUFFER_DEPTH)) begin
			add_code = ST_FULL;
		end else begin
			add_code = ST_ACCEPTED;
		end
	end

	// Extract checks that need no memory access.
	assign ext_early_err = (item.interval_end <= item.interval_start) || (gap_q == '0)
		|| (fill_q < CNT_W'(2));
	assign ext_code = (item.interval_end <= item.interval_start) ? ST_BAD_INTERVAL
		: ST_INSUFFICIENT;

	// Sample write on an accepted add.
	assign s_we    = item_accept && (item.kind == KIND_ADD) && (add_code == ST_ACCEPTED);
	assign s_waddr = slot_of(head_q, fill_q);
	always_comb begin
		s_wdata.stamp   = item.sample_time;
		s_wdata.comp[0] = item.accel_x;
		s_wdata.comp[1] = item.accel_y;
		s_wdata.comp[2] = item.accel_z;
		s_wdata.comp[3] = item.rate_x;
		s_wdata.comp[4] = item.rate_y;
		s_wdata.comp[5] = item.rate_z;
	end

	// Bracket scan decisions.
	assign scan_t        = s_rdata.stamp;
	assign scan_le_start = scan_t <= start_q;
	assign scan_ge_end   = scan_t >= end_q;
	assign scan_found    = pend_q && !scan_le_start && scan_ge_end;
	assign gap_hit       = (scan_t - prev_t_q) > STAMP_W'(gap_q);
	assign scan_issue    = (state_q == S_SCAN) && !scan_found && (iss_q < fill_q);

	// Knot selection: start knot interpolates left/left+1, end knot right-1/right.
	assign ia     = knot_end_q ? (right_q - 1'b1) : left_q;
	assign knot_t = knot_end_q ? end_q : start_q;

	// Sample read address.
	always_comb begin
		case (state_q)
			S_SCAN:  s_raddr = slot_of(head_q, iss_q);
			S_RDA:   s_raddr = slot_of(head_q, CNT_W'(ia));
			S_RDB:   s_raddr = slot_of(head_q, CNT_W'(ia) + CNT_W'(1));
			S_INNER: s_raddr = slot_of(head_q, CNT_W'(inner_q));
			default: s_raddr = head_q;
		endcase
	end

	// Segment values.
	assign dt = VAL_W'(kcur_t_q - kprev_t_q);
	always_comb begin
		for (int c = 0; c < NCOMP; c++) begin
			msum[c] = {kprev_q[c][VAL_W-1], kprev_q[c]} + {kcur_q[c][VAL_W-1], kcur_q[c]};
			mean[c] = msum[c][VAL_W:1];
		end
	end

	// Duration memory ports.
	assign d_we        = (state_q == S_SEG) && out_free;
	assign d_waddr     = seg_q[SEG_AW-1:0];
	assign mscan_issue = (state_q == S_MSCAN) && (i_q < seg_q);
	assign d_raddr     = (state_q == S_MSCAN) ? i_q[SEG_AW-1:0] : j_q[SEG_AW-1:0];

	// Median ranks and final figures.
	assign k1      = (seg_q - CNT_W'(1)) >> 1;
	assign k2      = seg_q >> 1;
	assign med_sum = {1'b0, sel1_q} + {1'b0, sel2_q};
	assign owned   = CNT_W'(right_q) - CNT_W'(left_q) - CNT_W'(1) + CNT_W'(eq_q);
	assign drop    = CNT_W'(right_q) + CNT_W'(eq_q) - CNT_W'(1);
	assign sum_tot = (SUMSQ_W + 2)'(sum_q) + (SUMSQ_W + 2)'(sq_s1);

	// Next result word.
	always_comb begin
		res_n    = '0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_accept) begin
					res_n.last = 1'b1;
					if (item.kind == KIND_ADD) begin
						res_n.status = add_code;
						res_load     = 1'b1;
					end else if (ext_early_err) begin
						res_n.status = ext_code;
						res_load     = 1'b1;
					end
				end
			end
			S_ERR: begin
				res_n.status = err_q;
				res_n.last   = 1'b1;
				res_load     = out_free;
			end
			S_SEG: begin
				res_n.status       = ST_SEGMENT;
				res_n.mean_accel_x = mean[0];
				res_n.mean_accel_y = mean[1];
				res_n.mean_accel_z = mean[2];
				res_n.mean_rate_x  = mean[3];
				res_n.mean_rate_y  = mean[4];
				res_n.mean_rate_z  = mean[5];
				res_n.segment_dt   = dt;
				res_load           = out_free;
			end
			S_FINAL: begin
				res_n.status         = ST_OK;
				res_n.median_dt      = med_sum[VAL_W:1];
				res_n.sum_dt_squared = sum_q;
				res_n.owned_count    = 6'(owned);
				res_n.last           = 1'b1;
				res_load             = out_free;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			last_q      <= '0;
			gap_q       <= GAP_RESET;
			start_q     <= '0;
			end_q       <= '0;
			prev_t_q    <= '0;
			iss_q       <= '0;
			pidx_q      <= '0;
			pend_q      <= 1'b0;
			left_q      <= '0;
			right_q     <= '0;
			inner_q     <= '0;
			have_left_q <= 1'b0;
			gapbad_q    <= 1'b0;
			eq_q        <= 1'b0;
			knot_end_q  <= 1'b0;
			err_q       <= ST_UNBRACKETED;
			a_q         <= '0;
			b_q         <= '0;
			comp_q      <= '0;
			kprev_q     <= '0;
			kcur_q      <= '0;
			kprev_t_q   <= '0;
			kcur_t_q    <= '0;
			seg_q       <= '0;
			sum_q       <= '0;
			sq_vld_s1   <= 1'b0;
			sq_s1       <= '0;
			j_q         <= '0;
			i_q         <= '0;
			lt_q        <= '0;
			le_q        <= '0;
			cand_q      <= '0;
			sel1_q      <= '0;
			sel2_q      <= '0;
			res_q       <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			// Configuration write.
			if (cfg_valid && cfg_ready) begin
				gap_q <= cfg_data;
			end

			// Output register.
			if (res_load) begin
				res_q     <= res_n;
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end

			// Saturating sum of squared durations.
			sq_vld_s1 <= 1'b0;
			if (sq_vld_s1) begin
				sum_q <= (sum_tot > (SUMSQ_W + 2)'(SAT63)) ? SAT63 : sum_tot[SUMSQ_W-1:0];
			end

			case (state_q)
				S_IDLE: begin
					if (item_accept) begin
						if (item.kind == KIND_ADD) begin
							if (add_code == ST_ACCEPTED) begin
								fill_q <= fill_q + 1'b1;
								last_q <= item.sample_time;
							end
						end else if (!ext_early_err) begin
							start_q     <= item.interval_start;
							end_q       <= item.interval_end;
							iss_q       <= '0;
							pend_q      <= 1'b0;
							have_left_q <= 1'b0;
							gapbad_q    <= 1'b0;
							seg_q       <= '0;
							sum_q       <= '0;
							sel1_q      <= '0;
							sel2_q      <= '0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Consume the stamp read in the previous cycle.
					if (pend_q) begin
						prev_t_q <= scan_t;
						if (scan_le_start) begin
							left_q      <= pidx_q[PTR_W-1:0];
							have_left_q <= 1'b1;
							gapbad_q    <= 1'b0;
						end else begin
							if (have_left_q && gap_hit) begin
								gapbad_q <= 1'b1;
							end
							if (scan_ge_end) begin
								right_q <= pidx_q[PTR_W-1:0];
								eq_q    <= (scan_t == end_q);
								state_q <= S_CHECK;
							end
						end
					end
					if (scan_issue) begin
						pend_q <= 1'b1;
						pidx_q <= iss_q;
						iss_q  <= iss_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (!pend_q && iss_q == fill_q) begin
						err_q   <= ST_UNBRACKETED;
						state_q <= S_ERR;
					end
				end
				S_CHECK: begin
					if (!have_left_q) begin
						err_q   <= ST_UNBRACKETED;
						state_q <= S_ERR;
					end else if (gapbad_q) begin
						err_q   <= ST_GAP;
						state_q <= S_ERR;
					end else begin
						knot_end_q <= 1'b0;
						state_q    <= S_RDA;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RDA: begin
					state_q <= S_RDB;
				end
				S_RDB: begin
					a_q     <= s_rdata;
					state_q <= S_LATB;
				end
				S_LATB: begin
					b_q     <= s_rdata;
					comp_q  <= '0;
					state_q <= S_IGO;
				end
				S_IGO: begin
					state_q <= S_IWAIT;
				end
				S_IWAIT: begin
					if (ip_done) begin
						if (knot_end_q) begin
							kcur_q[comp_q] <= ip_res;
						end else begin
							kprev_q[comp_q] <= ip_res;
						end
						if (comp_q == 3'(NCOMP - 1)) begin
							if (knot_end_q) begin
								kcur_t_q <= end_q;
								state_q  <= S_SEG;
							end else begin
								kprev_t_q <= start_q;
								inner_q   <= left_q + 1'b1;
								state_q   <= S_INNER;
							end
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= S_IGO;
						end
					end
				end
				S_INNER: begin
					if (inner_q < right_q) begin
						state_q <= S_INNER_W;
					end else begin
						knot_end_q <= 1'b1;
						state_q    <= S_RDA;
					end
				end
				S_INNER_W: begin
					kcur_q   <= s_rdata.comp;
					kcur_t_q <= s_rdata.stamp;
					inner_q  <= inner_q + 1'b1;
					state_q  <= S_SEG;
				end
				S_SEG: begin
					if (out_free) begin
						seg_q     <= seg_q + 1'b1;
						sq_vld_s1 <= 1'b1;
						sq_s1     <= (2 * VAL_W)'(dt) * (2 * VAL_W)'(dt);
						kprev_q   <= kcur_q;
						kprev_t_q <= kcur_t_q;
						if (knot_end_q) begin
							j_q     <= '0;
							state_q <= S_MLOAD;
						end else begin
							state_q <= S_INNER;
						end
					end
				end
				S_MLOAD: begin
					state_q <= S_MLOADW;
				end
				S_MLOADW: begin
					cand_q  <= d_rdata;
					i_q     <= '0;
					pend_q  <= 1'b0;
					lt_q    <= '0;
					le_q    <= '0;
					state_q <= S_MSCAN;
				end
				S_MSCAN: begin
					// Rank the candidate against every duration.
					if (pend_q) begin
						if (d_rdata < cand_q) begin
							lt_q <= lt_q + 1'b1;
						end
						if (d_rdata <= cand_q) begin
							le_q <= le_q + 1'b1;
						end
					end
					if (mscan_issue) begin
						i_q    <= i_q + 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (!pend_q && i_q == seg_q) begin
						state_q <= S_MEVAL;
					end
				end
				S_MEVAL: begin
					if (lt_q <= k1 && k1 < le_q) begin
						sel1_q <= cand_q;
					end
					if (lt_q <= k2 && k2 < le_q) begin
						sel2_q <= cand_q;
					end
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == seg_q) begin
						state_q <= S_FINAL;
					end else begin
						state_q <= S_MLOAD;
					end
				end
				S_FINAL: begin
					// Drop the samples the interval consumed.
					if (out_free) begin
						head_q  <= slot_of(head_q, drop);
						fill_q  <= fill_q - drop;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(BUFFER_DEPTH))
		else $error("ring fill beyond depth");

	a_interp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ip_done |-> state_q == S_IWAIT)
		else $error("interpolation finished outside its wait state");

	a_dur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_we |-> seg_q < CNT_W'(SEG_DEPTH))
		else $error("duration write beyond memory");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_n.status == ST_OK) |=> state_q == S_IDLE)
		else $error("sequencer not idle after final result");

endmodule
